### sv/uer_pkg.sv
package uer_pkg;

    // Divisor from echo time in microseconds to distance in centimeters
    localparam int unsigned CM_DIVISOR_DEF = 58;

    localparam int unsigned TRIG_LEN_W   = 8;
    localparam int unsigned TIME_W       = 16;
    localparam int unsigned DIST_W       = 11;
    localparam int unsigned CFG_INDEX_W  = 2;
    localparam int unsigned CFG_DATA_W   = 16;

    // Register map
    localparam logic [CFG_INDEX_W-1:0] REG_TRIGGER_LENGTH = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_ECHO_TIMEOUT   = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_MAX_ECHO       = 2'd2;

    localparam logic [TRIG_LEN_W-1:0] TRIGGER_LENGTH_RST = 8'd10;
    localparam logic [TIME_W-1:0]     ECHO_TIMEOUT_RST   = 16'd1000;
    localparam logic [TIME_W-1:0]     MAX_ECHO_RST       = 16'd38000;

    typedef enum logic [2:0] {
        PH_IDLE      = 3'd0,
        PH_TRIG      = 3'd1,
        PH_WAIT_LOW  = 3'd2,
        PH_WAIT_HIGH = 3'd3,
        PH_MEASURE   = 3'd4
    } phase_t;

    typedef struct packed {
        logic [TRIG_LEN_W-1:0] trigger_length_us;
        logic [TIME_W-1:0]     echo_timeout_us;
        logic [TIME_W-1:0]     max_echo_us;
    } cfg_t;

    typedef struct packed {
        logic              trigger_level;
        logic              busy_res;
        logic              result_valid;
        logic              timed_out;
        logic              saturated;
        logic [TIME_W-1:0] width_us;
        logic [DIST_W-1:0] distance_cm;
    } result_t;

endpackage

### sv/uer_channels.sv
interface uer_item_if;
    logic valid;
    logic ready;
    logic start_req;
    logic echo_level;

    modport source (output valid, output start_req, output echo_level, input ready);
    modport sink   (input valid, input start_req, input echo_level, output ready);
endinterface

interface uer_result_if;
    logic                         valid;
    logic                         ready;
    logic                         trigger_level;
    logic                         busy_res;
    logic                         result_valid;
    logic                         timed_out;
    logic                         saturated;
    logic [uer_pkg::TIME_W-1:0]   width_us;
    logic [uer_pkg::DIST_W-1:0]   distance_cm;

    modport source (
        output valid, output trigger_level, output busy_res, output result_valid,
        output timed_out, output saturated, output width_us, output distance_cm,
        input ready
    );
    modport sink (
        input valid, input trigger_level, input busy_res, input result_valid,
        input timed_out, input saturated, input width_us, input distance_cm,
        output ready
    );
endinterface

interface uer_cfg_if;
    logic                              valid;
    logic                              ready;
    logic [uer_pkg::CFG_INDEX_W-1:0]   index;
    logic [uer_pkg::CFG_DATA_W-1:0]    data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

### sv/uer_core.sv
module uer_core #(
    parameter int unsigned CM_DIVISOR = uer_pkg::CM_DIVISOR_DEF
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             fire,
    input  logic             start_req,
    input  logic             echo_level,
    input  uer_pkg::cfg_t    cfg,
    output uer_pkg::result_t res
);

    // Remainder counter tracks width modulo the divisor so distance needs no divider
    localparam int unsigned RemW  = (CM_DIVISOR > 1) ? $clog2(CM_DIVISOR) : 1;
    localparam int unsigned RemWp = RemW + 1;
    localparam logic [RemW:0] DivVal = RemWp'(CM_DIVISOR);
    localparam logic [uer_pkg::DIST_W-1:0] CmFirst =
        (CM_DIVISOR == 1) ? uer_pkg::DIST_W'(1) : '0;
    localparam logic [RemW-1:0] RemFirst = (CM_DIVISOR == 1) ? '0 : RemW'(1);

    uer_pkg::phase_t phase_reg, phase_next;
    logic [uer_pkg::TRIG_LEN_W-1:0] trigger_count_reg, trigger_count_next;
    logic [uer_pkg::TIME_W-1:0]     wait_count_reg, wait_count_next;
    logic [uer_pkg::TIME_W-1:0]     width_count_reg, width_count_next;
    logic [uer_pkg::DIST_W-1:0]     cm_count_reg, cm_count_next;
    logic [RemW-1:0]                rem_count_reg, rem_count_next;

    logic [uer_pkg::TRIG_LEN_W-1:0] tlen, trig_inc;
    logic [uer_pkg::TIME_W-1:0]     wmax, wait_inc, width_inc;
    logic [RemW:0]                  rem_plus;
    logic                           rem_wrap;
    logic [uer_pkg::DIST_W-1:0]     cm_step;
    logic [RemW-1:0]                rem_step;

    logic in_trig, in_wlow, in_whigh, in_meas, idle_like;
    logic go, go_short, trig_done;
    logic low_hold, high_hold, rise, wait_expired, tmo;
    logic rise_sat, meas_hold, meas_sat, meas_end, finish;

    // zero length / zero max act as one
    assign tlen = (cfg.trigger_length_us == '0) ? uer_pkg::TRIG_LEN_W'(1)
                                                : cfg.trigger_length_us;
    assign wmax = (cfg.max_echo_us == '0) ? uer_pkg::TIME_W'(1) : cfg.max_echo_us;

    assign trig_inc  = trigger_count_reg + 1'b1;
    assign wait_inc  = wait_count_reg + 1'b1;
    assign width_inc = width_count_reg + 1'b1;

    assign rem_plus = {1'b0, rem_count_reg} + 1'b1;
    assign rem_wrap = (rem_plus == DivVal);
    assign cm_step  = rem_wrap ? cm_count_reg + 1'b1 : cm_count_reg;
    assign rem_step = rem_wrap ? '0 : rem_plus[RemW-1:0];

    assign in_trig   = (phase_reg == uer_pkg::PH_TRIG);
    assign in_wlow   = (phase_reg == uer_pkg::PH_WAIT_LOW);
    assign in_whigh  = (phase_reg == uer_pkg::PH_WAIT_HIGH);
    assign in_meas   = (phase_reg == uer_pkg::PH_MEASURE);
    assign idle_like = !(in_trig || in_wlow || in_whigh || in_meas);

    assign go           = idle_like && start_req;
    assign go_short     = go && (tlen == uer_pkg::TRIG_LEN_W'(1));
    assign trig_done    = in_trig && (trig_inc >= tlen);
    assign low_hold     = in_wlow && echo_level;
    assign high_hold    = in_whigh && !echo_level;
    assign rise         = in_whigh && echo_level;
    assign wait_expired = (wait_count_reg >= cfg.echo_timeout_us);
    assign tmo          = (low_hold || high_hold) && wait_expired;
    assign rise_sat     = rise && (wmax == uer_pkg::TIME_W'(1));
    assign meas_hold    = in_meas && echo_level;
    assign meas_sat     = meas_hold && (width_inc >= wmax);
    assign meas_end     = in_meas && !echo_level;
    assign finish       = tmo || rise_sat || meas_sat || meas_end;

    // next phase
    always_comb
    begin
        phase_next = phase_reg;
        if (fire)
        begin
            case (phase_reg)
                uer_pkg::PH_TRIG:
                begin
                    if (trig_done)
                    begin
                        phase_next = uer_pkg::PH_WAIT_LOW;
                    end
                end
                uer_pkg::PH_WAIT_LOW:
                begin
                    if (tmo)
                    begin
                        phase_next = uer_pkg::PH_IDLE;
                    end
                    else if (!echo_level)
                    begin
                        phase_next = uer_pkg::PH_WAIT_HIGH;
                    end
                end
                uer_pkg::PH_WAIT_HIGH:
                begin
                    if (tmo || rise_sat)
                    begin
                        phase_next = uer_pkg::PH_IDLE;
                    end
                    else if (rise)
                    begin
                        phase_next = uer_pkg::PH_MEASURE;
                    end
                end
                uer_pkg::PH_MEASURE:
                begin
                    if (meas_sat || meas_end)
                    begin
                        phase_next = uer_pkg::PH_IDLE;
                    end
                end
                default:
                begin
                    if (go_short)
                    begin
                        phase_next = uer_pkg::PH_WAIT_LOW;
                    end
                    else if (go)
                    begin
                        phase_next = uer_pkg::PH_TRIG;
                    end
                    else
                    begin
                        phase_next = uer_pkg::PH_IDLE;
                    end
                end
            endcase
        end
    end

    // counters
    always_comb
    begin
        trigger_count_next = trigger_count_reg;
        wait_count_next    = wait_count_reg;
        width_count_next   = width_count_reg;
        cm_count_next      = cm_count_reg;
        rem_count_next     = rem_count_reg;
        if (fire)
        begin
            if (go)
            begin
                trigger_count_next = uer_pkg::TRIG_LEN_W'(1);
            end
            else if (in_trig)
            begin
                trigger_count_next = trig_inc;
            end

            if (go_short || trig_done)
            begin
                wait_count_next = '0;
            end
            else if ((low_hold || high_hold) && !wait_expired)
            begin
                wait_count_next = wait_inc;
            end

            if (rise)
            begin
                width_count_next = uer_pkg::TIME_W'(1);
                cm_count_next    = CmFirst;
                rem_count_next   = RemFirst;
            end
            else if (meas_hold)
            begin
                width_count_next = width_inc;
                cm_count_next    = cm_step;
                rem_count_next   = rem_step;
            end
        end
    end

    // result for this tick
    always_comb
    begin
        res               = '0;
        res.trigger_level = go || in_trig;
        res.busy_res      = (go || !idle_like) && !finish;
        res.result_valid  = finish;
        res.timed_out     = tmo;
        res.saturated     = rise_sat || meas_sat;
        if (rise_sat)
        begin
            res.width_us    = uer_pkg::TIME_W'(1);
            res.distance_cm = CmFirst;
        end
        else if (meas_sat)
        begin
            res.width_us    = width_inc;
            res.distance_cm = cm_step;
        end
        else if (meas_end)
        begin
            res.width_us    = width_count_reg;
            res.distance_cm = cm_count_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg         <= uer_pkg::PH_IDLE;
            trigger_count_reg <= '0;
            wait_count_reg    <= '0;
            width_count_reg   <= '0;
            cm_count_reg      <= '0;
            rem_count_reg     <= '0;
        end
        else
        begin
            phase_reg         <= phase_next;
            trigger_count_reg <= trigger_count_next;
            wait_count_reg    <= wait_count_next;
            width_count_reg   <= width_count_next;
            cm_count_reg      <= cm_count_next;
            rem_count_reg     <= rem_count_next;
        end
    end

    a_rem_bound: assert property (@(posedge clk) disable iff (!rst_n)
        {1'b0, rem_count_reg} < DivVal)
        else $error("remainder counter out of range");

    a_meas_width: assert property (@(posedge clk) disable iff (!rst_n)
        in_meas |-> (width_count_reg != '0))
        else $error("measuring with zero width");

    a_one_finish: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0({tmo, rise_sat, meas_sat, meas_end}))
        else $error("more than one finish cause");

    a_width_cm: assert property (@(posedge clk) disable iff (!rst_n)
        (fire && rise) |=> (width_count_reg == uer_pkg::TIME_W'(1)))
        else $error("width not started at one");

endmodule

### sv/ultrasonic_echo_ranger.sv
// Ultrasonic echo ranger. Each request on the item channel is one microsecond
// tick carrying a start request and the sampled echo pin level, and each one
// yields exactly one result request: the trigger pin level for that tick,
// busy, and on the finishing tick the echo width in microseconds and the
// distance in centimeters (width / CM_DIVISOR, truncated), with timed_out or
// saturated flags. A start while idle drives the trigger for
// trigger_length_us ticks, then the block waits for an earlier echo to drop
// and for the new echo to rise, both waits sharing echo_timeout_us; the echo
// high time is then counted up to max_echo_us. One tick is accepted every
// clock cycle while item.ready is high; its result is registered in the
// output or skid register; the phase update is one registered controller step.
// A two-entry output stage (output register plus skid register) lets the
// block take a tick while a result is still waiting; item.ready drops only
// when both entries are full. Configuration writes are always accepted and
// must be issued while the block is idle. No clearing pass after reset.
module ultrasonic_echo_ranger #(
    parameter int unsigned CM_DIVISOR = uer_pkg::CM_DIVISOR_DEF
) (
    input  logic          clk,
    input  logic          rst_n,
    uer_item_if.sink      item,
    uer_result_if.source  result,
    uer_cfg_if.sink       cfg
);

    // Configuration registers
    uer_pkg::cfg_t cfg_reg, cfg_next;

    // Output stage: main register plus skid entry
    uer_pkg::result_t out_data_reg, out_data_next;
    uer_pkg::result_t skid_data_reg, skid_data_next;
    logic             out_valid_reg, out_valid_next;
    logic             skid_valid_reg, skid_valid_next;

    uer_pkg::result_t tick_res;
    logic             item_fire;
    logic             out_pop;

    // A tick is taken unless the skid entry is occupied
    assign item.ready = !skid_valid_reg;
    assign item_fire  = item.valid && item.ready;
    assign out_pop    = out_valid_reg && result.ready;

    // Register writes never stall
    assign cfg.ready = 1'b1;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg.valid)
        begin
            case (cfg.index)
                uer_pkg::REG_TRIGGER_LENGTH:
                    cfg_next.trigger_length_us = cfg.data[uer_pkg::TRIG_LEN_W-1:0];
                uer_pkg::REG_ECHO_TIMEOUT:
                    cfg_next.echo_timeout_us = cfg.data[uer_pkg::TIME_W-1:0];
                uer_pkg::REG_MAX_ECHO:
                    cfg_next.max_echo_us = cfg.data[uer_pkg::TIME_W-1:0];
                default:
                    cfg_next = cfg_reg;
            endcase
        end
    end

    // Controller and counters: one tick per accepted request
    uer_core #(
        .CM_DIVISOR (CM_DIVISOR)
    ) u_core (
        .clk        (clk),
        .rst_n      (rst_n),
        .fire       (item_fire),
        .start_req  (item.start_req),
        .echo_level (item.echo_level),
        .cfg        (cfg_reg),
        .res        (tick_res)
    );

    // Output stage steering. When the main register frees up, the skid entry
    // (if any) moves forward; otherwise the new result lands directly. When
    // the main register is held, a new result parks in the skid entry.
    always_comb
    begin
        out_valid_next  = out_valid_reg;
        out_data_next   = out_data_reg;
        skid_valid_next = skid_valid_reg;
        skid_data_next  = skid_data_reg;
        if (!out_valid_reg || out_pop)
        begin
            if (skid_valid_reg)
            begin
                out_valid_next  = 1'b1;
                out_data_next   = skid_data_reg;
                skid_valid_next = 1'b0;
            end
            else
            begin
                out_valid_next = item_fire;
                out_data_next  = tick_res;
            end
        end
        else if (item_fire)
        begin
            skid_valid_next = 1'b1;
            skid_data_next  = tick_res;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.trigger_length_us <= uer_pkg::TRIGGER_LENGTH_RST;
            cfg_reg.echo_timeout_us   <= uer_pkg::ECHO_TIMEOUT_RST;
            cfg_reg.max_echo_us       <= uer_pkg::MAX_ECHO_RST;
            out_valid_reg             <= 1'b0;
            skid_valid_reg            <= 1'b0;
        end
        else
        begin
            cfg_reg        <= cfg_next;
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    // Payload registers carry no reset
    always_ff @(posedge clk)
    begin
        out_data_reg  <= out_data_next;
        skid_data_reg <= skid_data_next;
    end

    assign result.valid         = out_valid_reg;
    assign result.trigger_level = out_data_reg.trigger_level;
    assign result.busy_res      = out_data_reg.busy_res;
    assign result.result_valid  = out_data_reg.result_valid;
    assign result.timed_out     = out_data_reg.timed_out;
    assign result.saturated     = out_data_reg.saturated;
    assign result.width_us      = out_data_reg.width_us;
    assign result.distance_cm   = out_data_reg.distance_cm;

    a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid_reg |-> out_valid_reg)
        else $error("skid entry occupied with empty output register");

    a_fire_lands: assert property (@(posedge clk) disable iff (!rst_n)
        (item_fire && !out_valid_reg) |=> out_valid_reg)
        else $error("accepted tick produced no result");

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        (skid_valid_reg && !out_pop) |=> skid_valid_reg)
        else $error("skid entry lost");

endmodule
